>>> sv/acr_pkg.sv
// Shared constants and types for the arc center block.
// No dependencies; the files that use it refer to it by scoped names.
package acr_pkg;

  localparam int unsigned RADIUS_WIDTH = 20;

  typedef struct packed {
    logic ccw;
    logic invalid;
  } arc_flags_t;

endpackage

>>> sv/acr_in_if.sv
// Input channel of the arc center block: valid/ready plus one arc command.
// Depends on acr_pkg.
interface acr_in_if #(
  parameter int COORD_WIDTH = 21
) ();
  logic                                 valid;
  logic                                 ready;
  logic signed [COORD_WIDTH-1:0]        start_x;
  logic signed [COORD_WIDTH-1:0]        start_y;
  logic signed [COORD_WIDTH-1:0]        end_x;
  logic signed [COORD_WIDTH-1:0]        end_y;
  logic [acr_pkg::RADIUS_WIDTH-1:0]     radius;
  logic                                 counter_clockwise;

  modport source (
    output valid, start_x, start_y, end_x, end_y, radius, counter_clockwise,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y, radius, counter_clockwise,
    output ready
  );
endinterface

>>> sv/acr_out_if.sv
// Result channel of the arc center block: valid/ready plus one center offset.
// No dependencies.
interface acr_out_if #(
  parameter int COORD_WIDTH = 21
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] center_offset_x;
  logic signed [COORD_WIDTH-1:0] center_offset_y;
  logic                          radius_invalid;

  modport source (
    output valid, center_offset_x, center_offset_y, radius_invalid,
    input  ready
  );
  modport sink (
    input  valid, center_offset_x, center_offset_y, radius_invalid,
    output ready
  );
endinterface

>>> sv/arc_center_from_radius.sv
// Arc center from endpoints and radius: top level. Depends on acr_pkg, acr_in_if,
// acr_out_if, acr_prep, acr_div, acr_sqrt and acr_post.
// Throughput: one transaction per cycle while the result side takes transactions.
// Reset: synchronous, active low; clears all valid bits, the pipeline comes up empty.
module arc_center_from_radius #(
  parameter int COORD_WIDTH        = 21,
  parameter int ROOT_FRACTION_BITS = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  acr_in_if.sink    in_ch,
  acr_out_if.source out_ch
);
  localparam int RB     = acr_pkg::RADIUS_WIDTH;
  localparam int DW     = COORD_WIDTH + 1;
  localparam int DEN_W  = 2 * (RB + 1);
  localparam int NUM_W  = DEN_W + 2 * ROOT_FRACTION_BITS;
  localparam int SW     = (NUM_W + 1) / 2;
  localparam int SIDE_W = $bits(acr_pkg::arc_flags_t) + 2 * DW;

  // One global advance: every stage moves when the output register is free or
  // being drained this cycle. Valid bits ride along, so bubbles pass harmlessly.
  logic en;
  logic post_vld;

  assign en          = !post_vld || out_ch.ready;
  assign in_ch.ready = en;

  // Chord, d = dx^2 + dy^2, radius check, divider operands.
  logic              prep_vld;
  logic [NUM_W-1:0]  prep_num;
  logic [DEN_W-1:0]  prep_den;
  logic [SIDE_W-1:0] prep_side;

  acr_prep #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_W      (ROOT_FRACTION_BITS)
  ) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_ch.valid),
    .start_x (in_ch.start_x),
    .start_y (in_ch.start_y),
    .end_x   (in_ch.end_x),
    .end_y   (in_ch.end_y),
    .radius  (in_ch.radius),
    .ccw     (in_ch.counter_clockwise),
    .vld_o   (prep_vld),
    .num_o   (prep_num),
    .den_o   (prep_den),
    .side_o  (prep_side)
  );

  // (4R^2 - d) * 2^(2F) / d, truncated, one bit per stage.
  logic              div_vld;
  logic [NUM_W-1:0]  div_quo;
  logic [SIDE_W-1:0] div_side;

  acr_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .SIDE_W (SIDE_W)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (prep_vld),
    .num_i  (prep_num),
    .den_i  (prep_den),
    .side_i (prep_side),
    .vld_o  (div_vld),
    .quo_o  (div_quo),
    .side_o (div_side)
  );

  // s = floor(sqrt(quotient)), one bit per stage.
  logic              sq_vld;
  logic [SW-1:0]     sq_root;
  logic [SIDE_W-1:0] sq_side;

  acr_sqrt #(
    .RT_W   (SW),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (div_vld),
    .rad_i  ((2*SW)'(div_quo)),
    .side_i (div_side),
    .vld_o  (sq_vld),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  // Offsets, rounding and saturation; holds the output register.
  acr_post #(
    .COORD_WIDTH (COORD_WIDTH),
    .FRAC_W      (ROOT_FRACTION_BITS),
    .RT_W        (SW)
  ) u_post (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (sq_vld),
    .root_i (sq_root),
    .side_i (sq_side),
    .vld_o  (post_vld),
    .ox_o   (out_ch.center_offset_x),
    .oy_o   (out_ch.center_offset_y),
    .inv_o  (out_ch.radius_invalid)
  );

  assign out_ch.valid = post_vld;
endmodule

>>> sv/acr_prep.sv
// Front end: chord, squared chord length, radius check and divider operands.
// Three register stages. Depends on acr_pkg.
module acr_prep #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_W      = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic signed [COORD_WIDTH-1:0]        start_x,
  input  logic signed [COORD_WIDTH-1:0]        start_y,
  input  logic signed [COORD_WIDTH-1:0]        end_x,
  input  logic signed [COORD_WIDTH-1:0]        end_y,
  input  logic [acr_pkg::RADIUS_WIDTH-1:0]     radius,
  input  logic                                 ccw,
  output logic                                 vld_o,
  output logic [2*(acr_pkg::RADIUS_WIDTH+1)+2*FRAC_W-1:0] num_o,
  output logic [2*(acr_pkg::RADIUS_WIDTH+1)-1:0]          den_o,
  output logic [$bits(acr_pkg::arc_flags_t)+2*(COORD_WIDTH+1)-1:0] side_o
);
  localparam int RB    = acr_pkg::RADIUS_WIDTH;
  localparam int DW    = COORD_WIDTH + 1;
  localparam int XW    = RB + 2;
  localparam int SQ_W  = 2 * (RB + 1);
  localparam int NUM_W = SQ_W + 2 * FRAC_W;
  localparam logic signed [63:0] LIM = 64'sd1 <<< (RB + 1);

  // stage A: chord and range check
  logic signed [DW-1:0] dx_nxt, dy_nxt;
  logic                 rng_nxt;
  logic                 a_vld_r, a_rng_r, a_ccw_r;
  logic signed [DW-1:0] a_dx_r, a_dy_r;
  logic [RB-1:0]        a_rad_r;

  assign dx_nxt  = DW'(end_x) - DW'(start_x);
  assign dy_nxt  = DW'(end_y) - DW'(start_y);
  assign rng_nxt = (64'(dx_nxt) > -LIM) && (64'(dx_nxt) < LIM) &&
                   (64'(dy_nxt) > -LIM) && (64'(dy_nxt) < LIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx_r  <= dx_nxt;
      a_dy_r  <= dy_nxt;
      a_rng_r <= rng_nxt;
      a_rad_r <= radius;
      a_ccw_r <= ccw;
    end
  end

  // stage B: squares
  logic signed [XW-1:0]   dxn, dyn;
  logic signed [2*XW-1:0] sqx_full, sqy_full;
  logic [2*RB-1:0]        r2_nxt;
  logic                   b_vld_r, b_rng_r, b_ccw_r;
  logic signed [DW-1:0]   b_dx_r, b_dy_r;
  logic [SQ_W-1:0]        b_sqx_r, b_sqy_r;
  logic [2*RB-1:0]        b_r2_r;

  assign dxn      = XW'(a_dx_r);
  assign dyn      = XW'(a_dy_r);
  assign sqx_full = dxn * dxn;
  assign sqy_full = dyn * dyn;
  assign r2_nxt   = a_rad_r * a_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (en) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_dx_r  <= a_dx_r;
      b_dy_r  <= a_dy_r;
      b_rng_r <= a_rng_r;
      b_ccw_r <= a_ccw_r;
      b_sqx_r <= sqx_full[SQ_W-1:0];
      b_sqy_r <= sqy_full[SQ_W-1:0];
      b_r2_r  <= r2_nxt;
    end
  end

  // stage C: d, validity, divider operands
  logic [SQ_W:0]       d_sum;
  logic [SQ_W-1:0]     four_r2, diff;
  logic                ok;
  acr_pkg::arc_flags_t flags_nxt;
  logic                c_vld_r;
  logic [NUM_W-1:0]    c_num_r;
  logic [SQ_W-1:0]     c_den_r;
  logic [$bits(acr_pkg::arc_flags_t)+2*DW-1:0] c_side_r;

  assign d_sum   = (SQ_W+1)'(b_sqx_r) + (SQ_W+1)'(b_sqy_r);
  assign four_r2 = {b_r2_r, 2'b00};
  assign ok      = b_rng_r && (d_sum != '0) && ((SQ_W+1)'(four_r2) > d_sum);
  assign diff    = four_r2 - d_sum[SQ_W-1:0];
  assign flags_nxt.ccw     = b_ccw_r;
  assign flags_nxt.invalid = !ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (en) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num_r  <= ok ? {diff, {(2*FRAC_W){1'b0}}} : '0;
      c_den_r  <= ok ? d_sum[SQ_W-1:0] : '0;
      c_side_r <= {flags_nxt, b_dx_r, b_dy_r};
    end
  end

  assign vld_o  = c_vld_r;
  assign num_o  = c_num_r;
  assign den_o  = c_den_r;
  assign side_o = c_side_r;
endmodule

>>> sv/acr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// No dependencies.
module acr_div #(
  parameter int NUM_W  = 90,
  parameter int DEN_W  = 42,
  parameter int SIDE_W = 46
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [NUM_W-1:0]  quo_o,
  output logic [SIDE_W-1:0] side_o
);
  logic              vld_r  [NUM_W];
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  nq_r   [NUM_W];
  logic [DEN_W-1:0]  den_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  for (genvar k = 0; k < NUM_W; k++) begin : g_stage
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in, den_in, rem_nxt;
    logic [NUM_W-1:0]  nq_in, nq_nxt;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign nq_in   = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign nq_in   = nq_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    // shift in the next dividend bit, subtract where it fits
    assign trial   = {rem_in, nq_in[NUM_W-1]};
    assign ge      = trial >= {1'b0, den_in};
    assign diff    = trial - {1'b0, den_in};
    assign rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    assign nq_nxt  = {nq_in[NUM_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        nq_r[k]   <= nq_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NUM_W-1];
  assign quo_o  = nq_r[NUM_W-1];
  assign side_o = side_r[NUM_W-1];
endmodule

>>> sv/acr_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband.
// No dependencies.
module acr_sqrt #(
  parameter int RT_W   = 45,
  parameter int SIDE_W = 46
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              vld_i,
  input  logic [2*RT_W-1:0] rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              vld_o,
  output logic [RT_W-1:0]   root_o,
  output logic [SIDE_W-1:0] side_o
);
  localparam int IN_W = 2 * RT_W;
  localparam int TR_W = RT_W + 3;

  logic              vld_r  [RT_W];
  logic [RT_W:0]     rem_r  [RT_W];
  logic [RT_W-1:0]   root_r [RT_W];
  logic [IN_W-1:0]   x_r    [RT_W];
  logic [SIDE_W-1:0] side_r [RT_W];

  for (genvar k = 0; k < RT_W; k++) begin : g_stage
    logic              vld_in;
    logic [RT_W:0]     rem_in, rem_nxt;
    logic [RT_W-1:0]   root_in, root_nxt;
    logic [IN_W-1:0]   x_in, x_nxt;
    logic [SIDE_W-1:0] side_in;
    logic [TR_W-1:0]   trial, cand, diff;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = vld_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign x_in    = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign x_in    = x_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down two bits, try root*4+1
    assign trial    = {rem_in, x_in[IN_W-1:IN_W-2]};
    assign cand     = TR_W'({root_in, 2'b01});
    assign ge       = trial >= cand;
    assign diff     = trial - cand;
    assign rem_nxt  = ge ? diff[RT_W:0] : trial[RT_W:0];
    assign root_nxt = {root_in[RT_W-2:0], ge};
    assign x_nxt    = {x_in[IN_W-3:0], 2'b00};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        x_r[k]    <= x_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[RT_W-1];
  assign root_o = root_r[RT_W-1];
  assign side_o = side_r[RT_W-1];
endmodule

>>> sv/acr_post.sv
// Back end: offset products, sums, rounding half away from zero, saturation.
// Four register stages, the last is the output register. Depends on acr_pkg.
module acr_post #(
  parameter int COORD_WIDTH = 21,
  parameter int FRAC_W      = 24,
  parameter int RT_W        = 45
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic [RT_W-1:0]                      root_i,
  input  logic [$bits(acr_pkg::arc_flags_t)+2*(COORD_WIDTH+1)-1:0] side_i,
  output logic                                 vld_o,
  output logic signed [COORD_WIDTH-1:0]        ox_o,
  output logic signed [COORD_WIDTH-1:0]        oy_o,
  output logic                                 inv_o
);
  localparam int CW    = COORD_WIDTH;
  localparam int DW    = CW + 1;
  localparam int PRD_W = DW + RT_W + 1;
  localparam int PW    = PRD_W + 1;
  localparam int RW    = PW - FRAC_W - 1;
  localparam logic [RW-1:0] MAX_MAG = RW'((64'd1 << (CW - 1)) - 64'd1);

  function automatic logic [RW-1:0] round_mag(input logic signed [PW-1:0] v);
    logic [PW-1:0] mag;
    logic [PW-1:0] sum;
    mag = v[PW-1] ? PW'(-v) : PW'(v);
    sum = mag + (PW'(1) << FRAC_W);
    return sum[PW-1:FRAC_W+1];
  endfunction

  function automatic logic [CW-1:0] saturate(input logic [RW-1:0] m, input logic neg);
    logic [CW-1:0] res;
    if (neg) begin
      res = (m > MAX_MAG + RW'(1)) ? {1'b1, {(CW-1){1'b0}}} : CW'(0) - m[CW-1:0];
    end else begin
      res = (m > MAX_MAG) ? {1'b0, {(CW-1){1'b1}}} : m[CW-1:0];
    end
    return res;
  endfunction

  acr_pkg::arc_flags_t  flags_in;
  logic signed [DW-1:0] dx_in, dy_in;
  logic signed [RT_W:0] s_sg;
  logic signed [PRD_W-1:0] tx_nxt, ty_nxt;

  assign flags_in = acr_pkg::arc_flags_t'(side_i[2*DW +: $bits(acr_pkg::arc_flags_t)]);
  assign dx_in    = side_i[DW +: DW];
  assign dy_in    = side_i[0 +: DW];
  // invalid radius: drop the root, leaving only the rounded half chord
  assign s_sg     = flags_in.invalid ? '0 : {1'b0, root_i};
  assign tx_nxt   = dy_in * s_sg;
  assign ty_nxt   = dx_in * s_sg;

  // stage 1: products
  logic                    p1_vld_r;
  acr_pkg::arc_flags_t     p1_flags_r;
  logic signed [DW-1:0]    p1_dx_r, p1_dy_r;
  logic signed [PRD_W-1:0] p1_tx_r, p1_ty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (en) begin
      p1_vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_flags_r <= flags_in;
      p1_dx_r    <= dx_in;
      p1_dy_r    <= dy_in;
      p1_tx_r    <= tx_nxt;
      p1_ty_r    <= ty_nxt;
    end
  end

  // stage 2: scaled half chord plus or minus the perpendicular term
  logic signed [PW-1:0] xs, ys, ox_nxt, oy_nxt;
  logic                 p2_vld_r;
  logic                 p2_inv_r;
  logic signed [PW-1:0] p2_ox_r, p2_oy_r;

  assign xs     = PW'(p1_dx_r) <<< FRAC_W;
  assign ys     = PW'(p1_dy_r) <<< FRAC_W;
  assign ox_nxt = p1_flags_r.ccw ? xs - PW'(p1_tx_r) : xs + PW'(p1_tx_r);
  assign oy_nxt = p1_flags_r.ccw ? ys + PW'(p1_ty_r) : ys - PW'(p1_ty_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_inv_r <= p1_flags_r.invalid;
      p2_ox_r  <= ox_nxt;
      p2_oy_r  <= oy_nxt;
    end
  end

  // stage 3: rounded magnitudes
  logic          p3_vld_r, p3_inv_r, p3_nx_r, p3_ny_r;
  logic [RW-1:0] p3_mx_r, p3_my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_inv_r <= p2_inv_r;
      p3_nx_r  <= p2_ox_r[PW-1];
      p3_ny_r  <= p2_oy_r[PW-1];
      p3_mx_r  <= round_mag(p2_ox_r);
      p3_my_r  <= round_mag(p2_oy_r);
    end
  end

  // stage 4: sign and saturation into the output register
  logic                 o_vld_r, o_inv_r;
  logic signed [CW-1:0] o_x_r, o_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (en) begin
      o_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_inv_r <= p3_inv_r;
      o_x_r   <= saturate(p3_mx_r, p3_nx_r);
      o_y_r   <= saturate(p3_my_r, p3_ny_r);
    end
  end

  assign vld_o = o_vld_r;
  assign ox_o  = o_x_r;
  assign oy_o  = o_y_r;
  assign inv_o = o_inv_r;
endmodule

>>> bench/arc_center_from_radius_tb.sv
// Self-checking bench for arc_center_from_radius: valid/ready driver, result monitor and
// an independent fixed-point predictor of the arc center offset.
// Depends on acr_pkg, acr_in_if, acr_out_if and the arc_center_from_radius RTL.
module arc_center_from_radius_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = 21;
  localparam int FB = 24;
  localparam int RW = acr_pkg::RADIUS_WIDTH;
  localparam int DRAIN_CYCLES = 150;   // a little over the pipeline length
  localparam int STALL_LIMIT = 3000;   // cycles with no transaction on either side
  localparam int HOLD_CYCLES = 500;    // long receiver hold-off, fills the pipeline
  localparam int N_RANDOM = 1200;

  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [RW-1:0]        radius;
    logic                 ccw;
  } arc_cmd_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic                 invalid;
  } center_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  acr_in_if  #(.COORD_WIDTH(CW)) in_ch ();
  acr_out_if #(.COORD_WIDTH(CW)) out_ch ();

  arc_center_from_radius #(.COORD_WIDTH(CW), .ROOT_FRACTION_BITS(FB)) i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  arc_cmd_t arcs_to_send[$];
  center_t  centers_due[$];
  int       arcs_taken = 0;
  int       centers_seen = 0;
  int       n_invalid = 0;
  int       n_errors = 0;
  int       idle_cycles = 0;
  int       hold_left = 0;
  bit       hold_done = 0;

  // Divide by 2^sh and round half away from zero.
  function automatic longint round_away(longint num, int sh);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [CW-1:0] clip_coord(longint v);
    longint hi;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    if (v > hi) v = hi;
    if (v < -hi - 1) v = -hi - 1;
    return v[CW-1:0];
  endfunction

  // Exact fixed-point arc center: truncated root, offsets rounded half away from zero.
  function automatic center_t center_of(arc_cmd_t a);
    center_t     c;
    longint      dx, dy, ox, oy, s, tx, ty, lim;
    bit [127:0]  four_r2, d, q, t;
    bit          bad;
    dx = longint'(a.ex) - longint'(a.sx);
    dy = longint'(a.ey) - longint'(a.sy);
    lim = longint'(1) <<< (RW + 1);
    four_r2 = 128'(4) * a.radius * a.radius;
    bad = 1'b1;
    // long chords never form d: they are always beyond any radius
    if (dx > -lim && dx < lim && dy > -lim && dy < lim) begin
      d = 128'(dx * dx + dy * dy);
      if (d != 0 && four_r2 > d) begin
        q = ((four_r2 - d) << (2 * FB)) / d;
        s = 0;
        for (int b = 63; b >= 0; b--) begin
          t = 128'(s) | (128'(1) << b);
          if (t * t <= q) s = longint'(t);
        end
        tx = dy * s;
        ty = dx * s;
        if (!a.ccw) begin
          tx = -tx;
          ty = -ty;
        end
        ox = round_away((dx <<< FB) - tx, FB + 1);
        oy = round_away((dy <<< FB) + ty, FB + 1);
        bad = 1'b0;
      end
    end
    if (bad) begin
      ox = round_away(dx, 1);
      oy = round_away(dy, 1);
    end
    c.ox = clip_coord(ox);
    c.oy = clip_coord(oy);
    c.invalid = bad;
    return c;
  endfunction

  function automatic arc_cmd_t make_arc(longint sx, longint sy, longint ex, longint ey,
                                        longint r, bit ccw);
    arc_cmd_t a;
    a.sx = sx[CW-1:0];
    a.sy = sy[CW-1:0];
    a.ex = ex[CW-1:0];
    a.ey = ey[CW-1:0];
    a.radius = r[RW-1:0];
    a.ccw = ccw;
    return a;
  endfunction

  // Random arc: radius mostly at or above half the chord, random sizes and signs.
  function automatic arc_cmd_t random_arc();
    longint sx, sy, dx, dy, r, span;
    real    half;
    span = (($urandom_range(3) == 0) ? 20 : ($urandom_range(1) ? 3000 : 700000));
    sx = longint'($urandom_range(1999998)) - 999999;
    sy = longint'($urandom_range(1999998)) - 999999;
    dx = longint'($urandom_range(2 * span)) - span;
    dy = longint'($urandom_range(2 * span)) - span;
    half = $sqrt(real'(dx * dx + dy * dy)) / 2.0;
    case ($urandom_range(3))
      0: r = longint'(half);
      1: r = longint'(half) + $urandom_range(3);
      2: r = longint'(half) + $urandom_range(span);
      default: r = longint'(half) + $urandom_range(999999);
    endcase
    if (r > 999999) r = longint'($urandom_range(999999));
    return make_arc(sx, sy, sx + dx, sy + dy, r, 1'($urandom_range(1)));
  endfunction

  initial begin
    arc_cmd_t a;
    // extremes, start equals end, zero and maximum radius, exact half chord
    arcs_to_send.push_back(make_arc(0, 0, 0, 0, 0, 1));
    arcs_to_send.push_back(make_arc(5, -7, 5, -7, 999999, 0));
    arcs_to_send.push_back(make_arc(0, 0, 100, 0, 50, 1));
    arcs_to_send.push_back(make_arc(0, 0, 100, 0, 51, 1));
    arcs_to_send.push_back(make_arc(0, 0, 100, 0, 51, 0));
    arcs_to_send.push_back(make_arc(0, 0, 3, 4, 0, 0));
    arcs_to_send.push_back(make_arc(0, 0, -3, -5, 2, 1));
    arcs_to_send.push_back(make_arc(0, 0, 1, 0, 1048575, 1));
    arcs_to_send.push_back(make_arc(0, 0, 0, -1, 1048575, 0));
    arcs_to_send.push_back(make_arc(-999999, -999999, 999999, 999999, 999999, 1));
    arcs_to_send.push_back(make_arc(-999999, 0, 999999, 0, 999999, 0));
    arcs_to_send.push_back(make_arc(-1048576, -1048576, 1048575, 1048575, 1048575, 1));
    arcs_to_send.push_back(make_arc(1048575, 0, -1048576, 0, 1048575, 0));
    arcs_to_send.push_back(make_arc(0, 0, 0, 1048575, 600000, 1));
    arcs_to_send.push_back(make_arc(999999, 999999, 999998, 999998, 999999, 1));
    arcs_to_send.push_back(make_arc(999999, 999999, 999998, 999998, 999999, 0));
    arcs_to_send.push_back(make_arc(0, 0, 1, 1, 1, 1));
    arcs_to_send.push_back(make_arc(0, 0, -1, 1, 1, 0));
    arcs_to_send.push_back(make_arc(10, 20, 1000, -2000, 1118, 1));
    arcs_to_send.push_back(make_arc(0, 0, -999999, 999999, 707106, 0));
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(99) < 15) begin
        // raw bit patterns: every input bit toggles, mostly invalid radius
        a.sx = CW'($urandom);
        a.sy = CW'($urandom);
        a.ex = CW'($urandom);
        a.ey = CW'($urandom);
        a.radius = RW'($urandom);
        a.ccw = 1'($urandom);
      end else begin
        a = random_arc();
      end
      arcs_to_send.push_back(a);
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // drain: all sent, all results back, then let the pipeline settle
    while (arcs_to_send.size() != 0 || in_ch.valid || centers_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d arcs, %0d with radius flagged invalid, incl. a %0d-cycle output hold.",
             centers_seen, n_invalid, HOLD_CYCLES);
    if (n_errors == 0 && centers_due.size() == 0 && out_ch.valid !== 1'b1)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Sender idle rate per phase: light, then heavy, then none.
  function automatic int send_idle_pct();
    if (arcs_taken < 420) return 10;
    if (arcs_taken < 820) return 66;
    return 0;
  endfunction

  function automatic int take_idle_pct();
    if (arcs_taken < 420) return 66;
    if (arcs_taken < 820) return 10;
    return 0;
  endfunction

  // Driver: record the prediction on each accepted transaction, then advance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.start_x <= '0;
      in_ch.start_y <= '0;
      in_ch.end_x <= '0;
      in_ch.end_y <= '0;
      in_ch.radius <= '0;
      in_ch.counter_clockwise <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        centers_due.push_back(center_of(make_arc(in_ch.start_x, in_ch.start_y, in_ch.end_x,
                                                 in_ch.end_y, in_ch.radius,
                                                 in_ch.counter_clockwise)));
        arcs_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (arcs_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          arc_cmd_t a;
          a = arcs_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.start_x <= a.sx;
          in_ch.start_y <= a.sy;
          in_ch.end_x <= a.ex;
          in_ch.end_y <= a.ey;
          in_ch.radius <= a.radius;
          in_ch.counter_clockwise <= a.ccw;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (centers_due.size() == 0) begin
          $display("%t: unexpected result ox=%0d oy=%0d inv=%0b", $realtime,
                   out_ch.center_offset_x, out_ch.center_offset_y, out_ch.radius_invalid);
          n_errors++;
        end else begin
          center_t c;
          c = centers_due.pop_front();
          if (out_ch.center_offset_x !== c.ox || out_ch.center_offset_y !== c.oy ||
              out_ch.radius_invalid !== c.invalid) begin
            $display("%t: mismatch expected ox=%0d oy=%0d inv=%0b, got ox=%0d oy=%0d inv=%0b",
                     $realtime, c.ox, c.oy, c.invalid, out_ch.center_offset_x,
                     out_ch.center_offset_y, out_ch.radius_invalid);
            n_errors++;
          end
          if (c.invalid) n_invalid++;
        end
        centers_seen++;
      end
      // hold off once for long enough that the block stalls its input
      if (!hold_done && centers_seen == 60) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= take_idle_pct());
      end
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("%t: timeout, no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

endmodule
